FILE: hw/rtl/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg
// Shared types, codes and reset values of the credential entry lock.
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int KEY_W  = 8;
  localparam int LEN_W  = 6;
  localparam int TRY_W  = 4;
  localparam int LOCK_W = 6;
  localparam int EV_W   = 4;
  localparam int PH_W   = 3;
  localparam int CFG_AW = 3;
  localparam int OUT_W  = 24;

  localparam int LINE_DEPTH_DEF    = 32;
  localparam int LOCKOUT_TICKS_DEF = 5;

  localparam logic [KEY_W-1:0] ENTER_RST     = 8'h0D;
  localparam logic [KEY_W-1:0] ALT_ENTER_RST = 8'h0F;
  localparam logic [KEY_W-1:0] BKSP_RST      = 8'h08;
  localparam logic [TRY_W-1:0] TRIES_RST     = 4'd3;
  localparam logic [LEN_W-1:0] MIN_LEN_RST   = 6'd5;
  localparam logic [LEN_W-1:0] MAX_LEN_RST   = 6'd20;

  typedef enum logic [CFG_AW-1:0] {
    REG_ENTER,
    REG_ALT_ENTER,
    REG_BKSP,
    REG_TRY_LIMIT,
    REG_NAME_MIN,
    REG_NAME_MAX,
    REG_PASS_MIN,
    REG_PASS_MAX
  } cfg_reg_t;

  typedef enum logic [EV_W-1:0] {
    EV_IGNORED,
    EV_CHAR,
    EV_ERASE,
    EV_SHORT,
    EV_NAME_SET,
    EV_PASS_SET,
    EV_NAME_TAKEN,
    EV_OK,
    EV_FAIL,
    EV_LOCK_TICK
  } event_t;

  typedef enum logic [PH_W-1:0] {
    PH_ENROL_NAME,
    PH_ENROL_PASS,
    PH_CHECK_NAME,
    PH_CHECK_PASS,
    PH_LOCKED
  } phase_t;

  typedef struct packed {
    logic step;
    logic cmp_start;
    logic cmp_run;
    logic finish;
  } cel_cmd_t;

  typedef struct packed {
    logic need_cmp;
    logic cmp_done;
  } cel_stat_t;

endpackage

FILE: hw/rtl/cel_datapath.sv
// ----------------------------------------------------------------------------
// cel_datapath
// Line editing, credential stores, byte compare, tries and lockout counters.
// ----------------------------------------------------------------------------
module cel_datapath import cel_pkg::*; #(
  parameter int LINE_DEPTH    = LINE_DEPTH_DEF,
  parameter int LOCKOUT_TICKS = LOCKOUT_TICKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [KEY_W-1:0]  cfg_wdata,
  input  logic              in_cmd,
  input  logic [KEY_W-1:0]  in_key,
  input  cel_cmd_t          ctl,
  output cel_stat_t         sts,
  output logic [OUT_W-1:0]  out_data
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [LEN_W:0]    DEPTH_LIM = (LEN_W+1)'(LINE_DEPTH);
  localparam logic [LOCK_W-1:0] LOCK_LOAD = LOCK_W'(LOCKOUT_TICKS);

  logic [KEY_W-1:0] enter_r, alt_r, bksp_r;
  logic [TRY_W-1:0] tmax_r;
  logic [LEN_W-1:0] nmin_r, nmax_r, pmin_r, pmax_r;

  logic [KEY_W-1:0] name_mem [LINE_DEPTH];
  logic [KEY_W-1:0] pass_mem [LINE_DEPTH];
  logic [KEY_W-1:0] line_mem [LINE_DEPTH];

  phase_t            mode_r, mode_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  nlen_r, nlen_nxt, plen_r, plen_nxt;
  logic              match_r, match_nxt;
  logic [TRY_W-1:0]  tries_r, tries_nxt;
  logic [LOCK_W-1:0] lock_r, lock_nxt, lock_dec;
  event_t            ev_nxt;
  logic              wr_en, is_enter, is_bksp, name_line, need_cmp;
  logic [LEN_W-1:0]  max_sel, stored_len;
  logic [LEN_W:0]    lim;
  logic [AW-1:0]     wr_addr, rd_addr;

  logic [LEN_W-1:0] idx_r, cmp_len_r;
  logic             mism_r, rdv_r, cmp_pass_r, issue, pre_ok;
  logic [KEY_W-1:0] buf_q_r, sto_q_r;
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_r <= ENTER_RST;
      alt_r   <= ALT_ENTER_RST;
      bksp_r  <= BKSP_RST;
      tmax_r  <= TRIES_RST;
      nmin_r  <= MIN_LEN_RST;
      nmax_r  <= MAX_LEN_RST;
      pmin_r  <= MIN_LEN_RST;
      pmax_r  <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ENTER:     enter_r <= cfg_wdata;
        REG_ALT_ENTER: alt_r   <= cfg_wdata;
        REG_BKSP:      bksp_r  <= cfg_wdata;
        REG_TRY_LIMIT: tmax_r  <= cfg_wdata[TRY_W-1:0];
        REG_NAME_MIN:  nmin_r  <= cfg_wdata[LEN_W-1:0];
        REG_NAME_MAX:  nmax_r  <= cfg_wdata[LEN_W-1:0];
        REG_PASS_MIN:  pmin_r  <= cfg_wdata[LEN_W-1:0];
        REG_PASS_MAX:  pmax_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_enter   = (in_key == enter_r) || (in_key == alt_r);
  assign is_bksp    = (in_key == bksp_r);
  assign name_line  = (mode_r == PH_ENROL_NAME) || (mode_r == PH_CHECK_NAME);
  assign max_sel    = name_line ? nmax_r : pmax_r;
  assign lim        = ({1'b0, max_sel} < DEPTH_LIM) ? {1'b0, max_sel} : DEPTH_LIM;
  assign lock_dec   = (lock_r != '0) ? lock_r - 1'b1 : '0;
  assign stored_len = (mode_r == PH_CHECK_PASS) ? plen_r : nlen_r;
  assign pre_ok     = (cnt_r == stored_len) && ((mode_r == PH_CHECK_NAME) || match_r);

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    nlen_nxt  = nlen_r;
    plen_nxt  = plen_r;
    match_nxt = match_r;
    tries_nxt = tries_r;
    lock_nxt  = lock_r;
    ev_nxt    = EV_IGNORED;
    wr_en     = 1'b0;
    need_cmp  = 1'b0;
    if (ctl.finish) begin
      cnt_nxt = '0;
      if (mode_r == PH_CHECK_NAME) begin
        match_nxt = !mism_r;
        mode_nxt  = PH_CHECK_PASS;
        ev_nxt    = EV_NAME_TAKEN;
      end else begin
        mode_nxt = PH_CHECK_NAME;
        if (!mism_r) begin
          tries_nxt = tmax_r;
          ev_nxt    = EV_OK;
        end else begin
          ev_nxt = EV_FAIL;
          if (tries_r <= TRY_W'(1)) begin
            tries_nxt = '0;
            lock_nxt  = LOCK_LOAD;
            mode_nxt  = PH_LOCKED;
          end else begin
            tries_nxt = tries_r - 1'b1;
          end
        end
      end
    end else if (mode_r == PH_LOCKED) begin
      if (in_cmd) begin
        ev_nxt   = EV_LOCK_TICK;
        lock_nxt = lock_dec;
        if (lock_dec == '0) begin
          tries_nxt = tmax_r;
          mode_nxt  = PH_CHECK_NAME;
        end
      end
    end else if (!in_cmd) begin
      if (is_enter) begin
        if (cnt_r != '0) begin
          case (mode_r)
            PH_ENROL_NAME: begin
              cnt_nxt = '0;
              if (cnt_r < nmin_r) begin
                ev_nxt = EV_SHORT;
              end else begin
                nlen_nxt = cnt_r;
                mode_nxt = PH_ENROL_PASS;
                ev_nxt   = EV_NAME_SET;
              end
            end
            PH_ENROL_PASS: begin
              cnt_nxt = '0;
              if (cnt_r < pmin_r) begin
                ev_nxt = EV_SHORT;
              end else begin
                plen_nxt = cnt_r;
                mode_nxt = PH_CHECK_NAME;
                ev_nxt   = EV_PASS_SET;
              end
            end
            default: need_cmp = 1'b1;
          endcase
        end
      end else if (is_bksp) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          ev_nxt  = EV_ERASE;
        end
      end else if ({1'b0, cnt_r} < lim) begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        ev_nxt  = EV_CHAR;
      end
    end
  end

  assign sts.need_cmp = need_cmp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= PH_ENROL_NAME;
      cnt_r   <= '0;
      nlen_r  <= '0;
      plen_r  <= '0;
      match_r <= 1'b1;
      tries_r <= TRIES_RST;
      lock_r  <= '0;
    end else if (ctl.step || ctl.finish) begin
      mode_r  <= mode_nxt;
      cnt_r   <= cnt_nxt;
      nlen_r  <= nlen_nxt;
      plen_r  <= plen_nxt;
      match_r <= match_nxt;
      tries_r <= tries_nxt;
      lock_r  <= lock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step || ctl.finish) begin
      out_data_r <= {1'b0, lock_nxt, tries_nxt, cnt_nxt, mode_nxt, ev_nxt};
    end
  end

  assign out_data = out_data_r;

  // enrolment characters go straight to their store
  assign wr_addr = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.step && wr_en && (mode_r == PH_ENROL_NAME)) begin
      name_mem[wr_addr] <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && wr_en && (mode_r == PH_ENROL_PASS)) begin
      pass_mem[wr_addr] <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && wr_en && !(mode_r == PH_ENROL_NAME) && !(mode_r == PH_ENROL_PASS)) begin
      line_mem[wr_addr] <= in_key;
    end
  end

  assign rd_addr = idx_r[AW-1:0];
  assign issue   = (idx_r != cmp_len_r);

  always_ff @(posedge clk) begin
    buf_q_r <= line_mem[rd_addr];
    sto_q_r <= cmp_pass_r ? pass_mem[rd_addr] : name_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      cmp_len_r  <= '0;
      mism_r     <= 1'b0;
      rdv_r      <= 1'b0;
      cmp_pass_r <= 1'b0;
    end else if (ctl.cmp_start) begin
      idx_r      <= '0;
      cmp_len_r  <= pre_ok ? stored_len : '0;
      mism_r     <= !pre_ok;
      rdv_r      <= 1'b0;
      cmp_pass_r <= (mode_r == PH_CHECK_PASS);
    end else if (ctl.cmp_run) begin
      if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      rdv_r <= issue;
      if (rdv_r && (buf_q_r != sto_q_r)) begin
        mism_r <= 1'b1;
      end
    end
  end

  assign sts.cmp_done = !rdv_r && !issue;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= DEPTH_LIM)
    else $error("line count beyond line depth");

  a_lock_tries: assert property (@(posedge clk) disable iff (!rst_n)
    (lock_r != '0) |-> (mode_r == PH_LOCKED) && (tries_r == '0))
    else $error("lockout running outside locked phase");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cmp_len_r)
    else $error("compare index past stored length");

endmodule

FILE: hw/rtl/cel_ctrl.sv
// ----------------------------------------------------------------------------
// cel_ctrl
// Handshake and sequencing: items taken in one step, or a byte compare pass.
// ----------------------------------------------------------------------------
module cel_ctrl import cel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  cel_stat_t sts,
  output cel_cmd_t  ctl
);

  typedef enum logic {S_IDLE, S_CMP} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, accept;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  assign ctl.step      = accept && !sts.need_cmp;
  assign ctl.cmp_start = accept && sts.need_cmp;
  assign ctl.cmp_run   = (state_r == S_CMP);
  assign ctl.finish    = (state_r == S_CMP) && sts.cmp_done && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (ctl.cmp_start) state_nxt = S_CMP;
      S_CMP:   if (ctl.finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (ctl.step || ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_cmp_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> !in_tready)
    else $error("input taken during compare");

  a_start_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cmp_start |=> (state_r == S_CMP))
    else $error("compare not entered");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.finish || ctl.step) |=> out_valid_r)
    else $error("result not presented");

endmodule

FILE: hw/rtl/credential_entry_lock.sv
// ----------------------------------------------------------------------------
// credential_entry_lock
// Keypad credential lock: enrolment, sign-in check and timed lockout.
// ----------------------------------------------------------------------------
// Key presses and ticks: result the cycle after accept; next item then if out_tready.
// Enter at a check phase: the line is compared with the stored length and entry,
// skipped when the line length or the username check already fails, by the
// byte-per-cycle compare through the stores' single read port.
// Reset is synchronous: control, lengths and lockout count cleared, tries and
// config registers reloaded; credential stores are undefined until written.
// ----------------------------------------------------------------------------
module credential_entry_lock import cel_pkg::*; #(
  parameter int LINE_DEPTH    = LINE_DEPTH_DEF,
  parameter int LOCKOUT_TICKS = LOCKOUT_TICKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [KEY_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [KEY_W-1:0]  in_tdata,   // key
  input  logic [0:0]        in_tuser,   // cmd
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // event_res, phase, line_length, tries_left,
                                        // lockout_left, zero pad
);

  cel_cmd_t  ctl;
  cel_stat_t sts;

  cel_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .ctl        (ctl)
  );

  cel_datapath #(
    .LINE_DEPTH    (LINE_DEPTH),
    .LOCKOUT_TICKS (LOCKOUT_TICKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (in_tuser[0]),
    .in_key    (in_tdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_data  (out_tdata)
  );

endmodule
